// ----- sv/isolated_cell_removal_filter_assert.svh -----
// ----------------------------------------------------------------------------
// isolated cell removal filter assertion macros
// concurrent property checks on aclk, held off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef ISOLATED_CELL_REMOVAL_FILTER_ASSERT_SVH
`define ISOLATED_CELL_REMOVAL_FILTER_ASSERT_SVH

// same-cycle implication
`define ICRF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ICRF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/icrf_pkg.sv -----
// ----------------------------------------------------------------------------
// icrf_pkg
// types and constants of the isolated cell removal filter
// ----------------------------------------------------------------------------
package icrf_pkg;

    localparam logic [7:0] OCCUPIED_VALUE = 8'd100;
    localparam int         CFG_DATA_W     = 9;
    localparam int         MAX_COUNT      = 224;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        CFG_GRID_WIDTH     = 2'd0,
        CFG_GRID_HEIGHT    = 2'd1,
        CFG_WINDOW_RADIUS  = 2'd2,
        CFG_MIN_NEIGHBOURS = 2'd3
    } cfg_index_t;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_CTR_RD  = 6'b000010,
        ST_CTR_CHK = 6'b000100,
        ST_SCAN    = 6'b001000,
        ST_DRAIN   = 6'b010000,
        ST_RESULT  = 6'b100000
    } state_t;

endpackage

// ----- sv/isolated_cell_removal_filter.sv -----
// ----------------------------------------------------------------------------
// isolated cell removal filter
// Keeps a grid of signed 8-bit cells in one single-port-read memory. A load
// transfer writes one cell; loads outside the configured grid are dropped. A
// query transfer reads the named cell; if it holds 100 a sequencer walks the
// clipped window of the configured radius, one memory read per cycle, and
// counts the other cells holding 100. Below the configured minimum the cell
// is reported as 0. A query of an occupied cell reads the centre cell, scans
// the window and drains its last read; a query of any other cell skips the
// scan, and one outside the grid also skips the centre read. The input is
// not ready while a query runs; a finished result waits in the output
// register while loads go on. The cell memory has no reset: read only
// written cells. The user must write configuration only while the block is
// idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "isolated_cell_removal_filter_assert.svh"

module isolated_cell_removal_filter #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 7
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  icrf_pkg::cfg_index_t              cfg_index,
    input  logic [icrf_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  icrf_pkg::req_type_t               s_req_type,
    input  logic [7:0]                        s_cell_x,
    input  logic [7:0]                        s_cell_y,
    input  logic signed [7:0]                 s_cell_value,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_out_x,
    output logic [7:0]                        m_out_y,
    output logic signed [7:0]                 m_filtered_value,
    output logic [7:0]                        m_neighbour_count,
    output logic                              m_in_range
);

    import icrf_pkg::*;

    localparam int         DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    localparam int         AW        = $clog2(DEPTH);
    localparam logic [8:0] WIDTH_CAP = (MAX_WIDTH > 511) ? 9'd511 : 9'(MAX_WIDTH);
    localparam logic [8:0] HEIGHT_CAP = (MAX_HEIGHT > 511) ? 9'd511 : 9'(MAX_HEIGHT);
    localparam logic [2:0] RADIUS_CAP = (MAX_RADIUS > 7) ? 3'd7 : 3'(MAX_RADIUS);

    function automatic logic [AW-1:0] cell_addr(input logic [7:0] col, input logic [7:0] row);
        return AW'(row) * AW'(MAX_WIDTH) + AW'(col);
    endfunction

    logic [8:0]        grid_width_reg, grid_width_next;
    logic [8:0]        grid_height_reg, grid_height_next;
    logic [2:0]        window_radius_reg, window_radius_next;
    logic [7:0]        min_neighbours_reg, min_neighbours_next;

    state_t            state_reg, state_next;
    logic              chk_valid_reg, chk_valid_next;
    logic              m_valid_reg, m_valid_next;

    logic [7:0]        col_reg, col_next;
    logic [7:0]        row_reg, row_next;
    logic [7:0]        x0_reg, x0_next;
    logic [7:0]        x1_reg, x1_next;
    logic [7:0]        y0_reg, y0_next;
    logic [7:0]        y1_reg, y1_next;
    logic [7:0]        sx_reg, sx_next;
    logic [7:0]        sy_reg, sy_next;
    logic [7:0]        count_reg, count_next;
    logic [7:0]        centre_reg, centre_next;
    logic              inside_reg, inside_next;

    logic [7:0]        out_x_reg, out_x_next;
    logic [7:0]        out_y_reg, out_y_next;
    logic signed [7:0] out_value_reg, out_value_next;
    logic [7:0]        out_count_reg, out_count_next;
    logic              out_in_range_reg, out_in_range_next;

    logic [7:0]        cell_store_reg [DEPTH];
    logic [7:0]        rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              mem_we;

    logic [8:0]        used_w;
    logic [8:0]        used_h;
    logic [2:0]        radius;
    logic              in_inside;
    logic [7:0]        in_x0;
    logic [7:0]        in_y0;
    logic [8:0]        x1_sum;
    logic [8:0]        y1_sum;
    logic [7:0]        in_x1;
    logic [7:0]        in_y1;
    logic              hit;
    logic              centre_occ;

    assign used_w    = (grid_width_reg > WIDTH_CAP) ? WIDTH_CAP : grid_width_reg;
    assign used_h    = (grid_height_reg > HEIGHT_CAP) ? HEIGHT_CAP : grid_height_reg;
    assign radius    = (window_radius_reg > RADIUS_CAP) ? RADIUS_CAP : window_radius_reg;
    assign in_inside = ({1'b0, s_cell_x} < used_w) && ({1'b0, s_cell_y} < used_h);

    // window bounds clipped at the grid edges
    assign in_x0  = (s_cell_x >= 8'(radius)) ? (s_cell_x - 8'(radius)) : 8'd0;
    assign in_y0  = (s_cell_y >= 8'(radius)) ? (s_cell_y - 8'(radius)) : 8'd0;
    assign x1_sum = {1'b0, s_cell_x} + 9'(radius);
    assign y1_sum = {1'b0, s_cell_y} + 9'(radius);
    assign in_x1  = (x1_sum >= used_w) ? 8'(used_w - 9'd1) : x1_sum[7:0];
    assign in_y1  = (y1_sum >= used_h) ? 8'(used_h - 9'd1) : y1_sum[7:0];

    assign hit        = chk_valid_reg && (rd_data_reg == OCCUPIED_VALUE);
    assign centre_occ = (centre_reg == OCCUPIED_VALUE);
    assign wr_addr    = cell_addr(s_cell_x, s_cell_y);

    assign cfg_ready         = 1'b1;
    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_out_x           = out_x_reg;
    assign m_out_y           = out_y_reg;
    assign m_filtered_value  = out_value_reg;
    assign m_neighbour_count = out_count_reg;
    assign m_in_range        = out_in_range_reg;

    always_comb begin
        grid_width_next     = grid_width_reg;
        grid_height_next    = grid_height_reg;
        window_radius_next  = window_radius_reg;
        min_neighbours_next = min_neighbours_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_GRID_WIDTH:     grid_width_next     = cfg_data;
                CFG_GRID_HEIGHT:    grid_height_next    = cfg_data;
                CFG_WINDOW_RADIUS:  window_radius_next  = cfg_data[2:0];
                CFG_MIN_NEIGHBOURS: min_neighbours_next = cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next        = state_reg;
        chk_valid_next    = 1'b0;
        m_valid_next      = m_valid_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        x0_next           = x0_reg;
        x1_next           = x1_reg;
        y0_next           = y0_reg;
        y1_next           = y1_reg;
        sx_next           = sx_reg;
        sy_next           = sy_reg;
        count_next        = hit ? (count_reg + 8'd1) : count_reg;
        centre_next       = centre_reg;
        inside_next       = inside_reg;
        out_x_next        = out_x_reg;
        out_y_next        = out_y_reg;
        out_value_next    = out_value_reg;
        out_count_next    = out_count_reg;
        out_in_range_next = out_in_range_reg;
        rd_addr           = cell_addr(col_reg, row_reg);
        mem_we            = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == REQ_LOAD) begin
                        mem_we = in_inside;
                    end else begin
                        col_next    = s_cell_x;
                        row_next    = s_cell_y;
                        x0_next     = in_x0;
                        x1_next     = in_x1;
                        y0_next     = in_y0;
                        y1_next     = in_y1;
                        inside_next = in_inside;
                        count_next  = 8'd0;
                        state_next  = in_inside ? ST_CTR_RD : ST_RESULT;
                    end
                end
            end
            ST_CTR_RD: begin
                state_next = ST_CTR_CHK;
            end
            ST_CTR_CHK: begin
                centre_next = rd_data_reg;
                sx_next     = x0_reg;
                sy_next     = y0_reg;
                state_next  = (rd_data_reg == OCCUPIED_VALUE) ? ST_SCAN : ST_RESULT;
            end
            ST_SCAN: begin
                rd_addr        = cell_addr(sx_reg, sy_reg);
                chk_valid_next = !((sx_reg == col_reg) && (sy_reg == row_reg));
                if (sx_reg == x1_reg) begin
                    sx_next = x0_reg;
                    if (sy_reg == y1_reg) begin
                        state_next = ST_DRAIN;
                    end else begin
                        sy_next = sy_reg + 8'd1;
                    end
                end else begin
                    sx_next = sx_reg + 8'd1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    out_x_next        = col_reg;
                    out_y_next        = row_reg;
                    out_in_range_next = inside_reg;
                    out_count_next    = inside_reg ? count_reg : 8'd0;
                    if (!inside_reg || (centre_occ && (count_reg < min_neighbours_reg))) begin
                        out_value_next = 8'sd0;
                    end else begin
                        out_value_next = signed'(centre_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg     <= 9'd256;
            grid_height_reg    <= 9'd256;
            window_radius_reg  <= 3'd6;
            min_neighbours_reg <= 8'd1;
            state_reg          <= ST_IDLE;
            chk_valid_reg      <= 1'b0;
            m_valid_reg        <= 1'b0;
            count_reg          <= 8'd0;
        end else begin
            grid_width_reg     <= grid_width_next;
            grid_height_reg    <= grid_height_next;
            window_radius_reg  <= window_radius_next;
            min_neighbours_reg <= min_neighbours_next;
            state_reg          <= state_next;
            chk_valid_reg      <= chk_valid_next;
            m_valid_reg        <= m_valid_next;
            count_reg          <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg          <= col_next;
        row_reg          <= row_next;
        x0_reg           <= x0_next;
        x1_reg           <= x1_next;
        y0_reg           <= y0_next;
        y1_reg           <= y1_next;
        sx_reg           <= sx_next;
        sy_reg           <= sy_next;
        centre_reg       <= centre_next;
        inside_reg       <= inside_next;
        out_x_reg        <= out_x_next;
        out_y_reg        <= out_y_next;
        out_value_reg    <= out_value_next;
        out_count_reg    <= out_count_next;
        out_in_range_reg <= out_in_range_next;
    end

    // cell memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_store_reg[wr_addr] <= s_cell_value;
        end
        rd_data_reg <= cell_store_reg[rd_addr];
    end

    `ICRF_ASSERT_IMP(a_scan_in_window, state_reg == ST_SCAN, (sx_reg >= x0_reg) && (sx_reg <= x1_reg) && (sy_reg >= y0_reg) && (sy_reg <= y1_reg), "scan position left the window")
    `ICRF_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= 8'(MAX_COUNT), "neighbour count above window size")
    `ICRF_ASSERT_IMP(a_out_of_range_zero, m_valid_reg && !out_in_range_reg, (out_value_reg == 8'sd0) && (out_count_reg == 8'd0), "out of range result not cleared")
    `ICRF_ASSERT_IMP(a_check_after_scan, chk_valid_reg, $past(state_reg == ST_SCAN), "window check without a scan read")
    `ICRF_ASSERT_NXT(a_result_to_idle, (state_reg == ST_RESULT) && (!m_valid_reg || m_ready), m_valid_reg && (state_reg == ST_IDLE), "result not handed to output register")

endmodule
